// File: hdl/bfwm_pkg.sv
// bfwm_pkg: shared constants and types for the box filter window mean block
// no dependencies
`default_nettype none
package bfwm_pkg;
  localparam int MAX_GRID   = 256;
  localparam int MAX_WINDOW = 8;
  localparam int GW = $clog2(MAX_GRID);
  localparam int WW = $clog2(MAX_WINDOW);
  localparam int SDEPTH = MAX_GRID * MAX_WINDOW;
  localparam int SAW = $clog2(SDEPTH);
  localparam logic [1:0] REG_GRID = 2'd0;
  localparam logic [1:0] REG_WIN  = 2'd1;

  typedef struct packed {
    logic signed [21:0] sum;
    logic [6:0]         area;
    logic [7:0]         row;
    logic [7:0]         col;
    logic               last;
  } win_t;
endpackage
`default_nettype wire

// File: hdl/bfwm_div.sv
// bfwm_div: rounded signed division of window sum*256 by the window area
// depends on bfwm_pkg; restoring divider, one quotient bit per cycle
`default_nettype none
module bfwm_div import bfwm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire win_t        job,
  output logic             busy,
  output logic             done,
  output logic [23:0]      q_out,
  output logic [7:0]       row_out,
  output logic [7:0]       col_out,
  output logic             last_out
);
  logic [30:0] num_r;
  logic [6:0]  den_r, rem_r;
  logic [4:0]  cnt_r;
  logic        busy_r, neg_r, done_r;
  logic [7:0]  row_r, col_r;
  logic        last_r;
  logic [29:0] mag;
  logic [7:0]  trial;
  logic [29:0] quo;

  assign mag = job.sum[21] ? 30'(-{{8{job.sum[21]}}, job.sum} * 256)
                           : 30'({8'd0, job.sum} * 256);
  assign trial = {rem_r, num_r[30]};
  assign quo = num_r[29:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd0;
        rem_r  <= 7'd0;
        num_r  <= {1'b0, mag + 30'(job.area >> 1)};
        den_r  <= job.area;
        neg_r  <= job.sum[21];
        row_r <= job.row; col_r <= job.col; last_r <= job.last;
      end else if (busy_r) begin
        if (trial >= {1'b0, den_r}) begin
          rem_r <= 7'(trial - {1'b0, den_r});
          num_r <= {num_r[29:0], 1'b1};
        end else begin
          rem_r <= trial[6:0];
          num_r <= {num_r[29:0], 1'b0};
        end
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd30) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end
  // after 31 shifts the low bits hold the quotient
  assign busy = busy_r;
  assign done = done_r;
  assign q_out = neg_r ? 24'(-quo[29:0]) : quo[23:0];
  assign row_out = row_r;
  assign col_out = col_r;
  assign last_out = last_r;
endmodule
`default_nettype wire

// File: hdl/box_filter_window_mean.sv
// box_filter_window_mean: streaming box filter over a square grid
// depends on bfwm_pkg, bfwm_div
// one sample per beat; the accepting edge reads line store and column sums, the next edge writes
// a sample closing no window passes ST_UPD, then ST_IDLE accepts the next beat
// a window-closing sample runs the 31-step serial divider, then out_tvalid is high in ST_OUT;
// the next sample is accepted only after out_tready takes the result beat
// reset (synchronous rst_n) clears position, window sum, column sum valid bits and FSM state
`default_nettype none
module box_filter_window_mean import bfwm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // sample
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // mean[23:0], out_row[31:24], out_col[39:32]
  output logic             out_tlast,  // frame_last
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  localparam logic [1:0] ST_IDLE = 2'd0, ST_UPD = 2'd1, ST_DIV = 2'd2, ST_OUT = 2'd3;

  logic [8:0] grid_r;
  logic [3:0] win_r;
  logic [1:0] st_r;
  logic [7:0] row_r, col_r;
  logic signed [21:0] wsum_r;
  logic signed [15:0] s_r;
  // memories: line store and column sums, both read synchronously into registers
  logic signed [15:0] store_mem [SDEPTH];
  logic signed [18:0] csum_mem [MAX_GRID];
  logic [MAX_GRID-1:0] cvalid_r;
  logic signed [15:0] old_s;
  logic signed [18:0] csum_c, csum_l;
  logic cv_c, cv_l;
  logic [8:0] g;
  logic [3:0] w;
  logic cfg_wr;
  logic [SAW-1:0] sidx;
  logic [7:0] lcol;
  logic signed [18:0] newc;
  logic signed [21:0] newsum;
  logic emit, dstart, dbusy, ddone, olast;
  logic [23:0] dq;
  logic [7:0] drow, dcol;
  logic [39:0] odata_r;
  logic olast_r;
  logic out_tlast_w;
  logic [2:0] rmod_r;
  win_t job;

  assign g = (grid_r == 9'd0) ? 9'd1 : (grid_r > 9'd256 ? 9'd256 : grid_r);
  assign w = (win_r == 4'd0) ? 4'd1 : (win_r > 4'd8 ? 4'd8 : win_r);
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  always_comb begin
    case ({1'b0, cfg_paddr[2]})
      REG_GRID: cfg_prdata = {23'd0, grid_r};
      default:  cfg_prdata = {28'd0, win_r};
    endcase
  end

  // row modulo window, tracked beside the row counter
  assign sidx = SAW'({rmod_r, col_r});
  assign lcol = col_r - 8'(w);

  assign in_tready = (st_r == ST_IDLE) && !cfg_wr;

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      old_s  <= store_mem[sidx];
      csum_c <= csum_mem[col_r];
      csum_l <= csum_mem[lcol];
      cv_c <= cvalid_r[col_r];
      cv_l <= cvalid_r[lcol];
      s_r <= signed'(in_tdata);
    end
    if (st_r == ST_UPD) begin
      store_mem[sidx] <= s_r;
      csum_mem[col_r] <= newc;
    end
  end

  // column and window sum update; left column sum was read before this write, col-w != col
  always_comb begin
    if (row_r == 8'd0) newc = 19'(s_r);
    else begin
      newc = (cv_c ? csum_c : 19'sd0) + 19'(s_r);
      if ({1'b0, row_r} >= {5'd0, w}) newc = newc - 19'(old_s);
    end
    if (col_r == 8'd0) newsum = 22'(newc);
    else begin
      newsum = wsum_r + 22'(newc);
      if ({1'b0, col_r} >= {5'd0, w}) newsum = newsum - 22'(cv_l ? csum_l : 19'sd0);
    end
  end

  assign emit = ({5'd0, w} <= g) && ({1'b0, row_r} + 9'd1 >= {5'd0, w})
                && ({1'b0, col_r} + 9'd1 >= {5'd0, w});
  assign olast = ({1'b0, row_r} == g - 9'd1) && ({1'b0, col_r} == g - 9'd1);
  assign dstart = (st_r == ST_UPD) && emit;
  assign job.sum = newsum;
  assign job.area = 7'({3'd0, w} * {3'd0, w});
  assign job.row = row_r + 8'd1 - 8'(w);
  assign job.col = col_r + 8'd1 - 8'(w);
  assign job.last = olast;

  bfwm_div u_div (.clk(clk), .rst_n(rst_n), .start(dstart), .job(job), .busy(dbusy),
    .done(ddone), .q_out(dq), .row_out(drow), .col_out(dcol), .last_out(out_tlast_w));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_r <= 9'd256; win_r <= 4'd3; st_r <= ST_IDLE;
      row_r <= 8'd0; col_r <= 8'd0; wsum_r <= 22'sd0; cvalid_r <= '0;
      rmod_r <= 3'd0;
    end else begin
      if (cfg_wr && cfg_paddr[1:0] == 2'd0) begin
        if ({1'b0, cfg_paddr[2]} == REG_GRID) grid_r <= cfg_pwdata[8:0];
        else win_r <= cfg_pwdata[3:0];
        row_r <= 8'd0; col_r <= 8'd0; wsum_r <= 22'sd0; rmod_r <= 3'd0;
      end
      case (st_r)
        ST_IDLE: if (in_tvalid && in_tready) st_r <= ST_UPD;
        ST_UPD: begin
          cvalid_r[col_r] <= 1'b1;
          wsum_r <= newsum;
          if ({1'b0, col_r} + 9'd1 >= g) begin
            col_r <= 8'd0;
            if ({1'b0, row_r} + 9'd1 >= g) begin
              row_r <= 8'd0;
              rmod_r <= 3'd0;
            end else begin
              row_r <= row_r + 8'd1;
              rmod_r <= ({1'b0, rmod_r} + 4'd1 == w) ? 3'd0 : rmod_r + 3'd1;
            end
          end else col_r <= col_r + 8'd1;
          st_r <= emit ? ST_DIV : ST_IDLE;
        end
        ST_DIV: if (ddone) st_r <= ST_OUT;
        ST_OUT: if (out_tready) st_r <= ST_IDLE;
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ddone) begin
      odata_r <= {dcol, drow, dq};
      olast_r <= out_tlast_w;
    end
  end
  assign out_tvalid = (st_r == ST_OUT);
  assign out_tdata = odata_r;
  assign out_tlast = olast_r;

  // divider only runs while waiting on it
  assert property (@(posedge clk) disable iff (!rst_n) dbusy |-> st_r == ST_DIV)
    else $error("divider busy outside divide state");
  assert property (@(posedge clk) disable iff (!rst_n) out_tvalid |-> !in_tready)
    else $error("input accepted while result pending");
  assert property (@(posedge clk) disable iff (!rst_n) ddone |-> st_r == ST_DIV)
    else $error("unexpected divider completion");
endmodule
`default_nettype wire
